FILE: hw/rtl/btps_pkg.sv
// Package for the box transit peak search core: sizes, state codes and
// the sequencer state enum. No dependencies.
`timescale 1ns / 1ps
package btps_pkg;
   localparam int MaxBins      = 1024;
   localparam int BinAw        = 10;
   localparam int MaxDurations = 256;

   localparam logic [0:0] CsrNumBins  = 1'd0;
   localparam logic [0:0] CsrS2nFloor = 1'd1;

   localparam logic KindLoad = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRIME,     // accumulate first window
      ST_SWEEP,     // slide box over bins, write window stores
      ST_EPOCH_RD,  // issue reads of three windows
      ST_MEAN,      // divide window sums by counts
      ST_SQRT,      // two square roots
      ST_DIV,       // final quotient
      ST_CMP,       // compare with best
      ST_DONE
   } state_type;
endpackage

FILE: hw/rtl/btps_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module btps_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hw/rtl/btps_divsqrt.sv
// Shared iterative unit: restoring divide (one quotient bit a cycle) or
// integer square root (one result bit a cycle). Uses btps_pkg.
`timescale 1ns / 1ps
module btps_divsqrt
   import btps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_sqrt,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] result
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        sq_ff, sq_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] rem_sh;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sq_in   = sq_ff;
      done_in = 1'b0;
      rem_sh  = '0;
      trial   = '0;
      if (start) begin
         rem_in  = '0;
         quo_in  = '0;
         num_in  = num;
         den_in  = den;
         sq_in   = is_sqrt;
         busy_in = 1'b1;
         cnt_in  = is_sqrt ? 7'd32 : 7'd64;
      end else if (busy_ff) begin
         if (sq_ff) begin
            // bring in two radicand bits, try 4r+1
            rem_sh = {rem_ff[61:0], num_ff[63:62]};
            trial  = {1'b0, rem_sh} - {1'b0, quo_ff[61:0], 2'b01};
            num_in = {num_ff[61:0], 2'b00};
         end else begin
            // bring in one dividend bit, try subtract divisor
            rem_sh = {rem_ff[62:0], num_ff[63]};
            trial  = {rem_ff[63], rem_sh} - {1'b0, den_ff};
            num_in = {num_ff[62:0], 1'b0};
         end
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      num_ff <= num_in;
      den_ff <= den_in;
      sq_ff  <= sq_in;
   end

   assign done   = done_ff;
   assign result = quo_ff;

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done not a pulse");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == 7'd0 || $past(start)) else $error("counter left");
`endif
endmodule

FILE: hw/rtl/box_transit_peak_search_core.sv
// Box transit peak search core: top level. Uses btps_pkg, btps_ram and
// the shared divide/square-root unit btps_divsqrt.
//
// Usage: pulse start with a word on the req_ ports while busy is low.
// kind 0 loads one phase bin and gives no result. kind 1
// evaluates one trial duration D over P = num_bins bins and gives one
// rsp_valid strobe with the best signal-to-noise, duration index and
// epoch so far.
// Work for a duration word: prime the first box sum over D bins and
// sweep it across all P bins, then per epoch three window reads, 4 divides,
// two square roots, a product step, a final divide and a compare, with
// less work when an epoch is skipped; all divides and roots run one after
// another on the single shared divide/root unit.
// A done state closes the item; busy drops as the result strobes, and a
// new word may be accepted in that cycle.
// csr_ writes set num_bins (index 0) and s2n_floor (index 1); write
// only while busy is low. Reset clears control state and the best
// registers; bin stores hold nothing valid until loaded. The receiver
// cannot stall: each result shows for one cycle.
`timescale 1ns / 1ps
module box_transit_peak_search_core
   import btps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic [9:0]          req_bin_index,
   input  logic signed [31:0]  req_bin_sum,
   input  logic [47:0]         req_bin_sqsum,
   input  logic [15:0]         req_bin_count,
   input  logic [10:0]         req_duration,
   input  logic                req_first_duration,
   input  logic                csr_wr_en,
   input  logic [0:0]          csr_index,
   input  logic [31:0]         csr_wr_data,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_best_s2n,
   output logic [7:0]          rsp_best_duration_index,
   output logic [9:0]          rsp_best_epoch
);
   state_type state_ff, state_in;

   logic [10:0] num_bins_ff;
   logic signed [31:0] floor_ff;
   logic [10:0] p_ff, p_in, d_ff, d_in;
   logic signed [31:0] best_ff, best_in;
   logic [7:0]  bidx_ff, bidx_in, dcnt_ff, dcnt_in;
   logic [9:0]  bbin_ff, bbin_in;
   logic [11:0] i_ff, i_in;     // sweep counter
   logic [9:0]  k_ff, k_in;     // epoch
   logic [2:0]  sub_ff, sub_in; // step within a phase
   logic signed [41:0] ts_ff, ts_in;
   logic [57:0] tq_ff, tq_in;
   logic [25:0] tc_ff, tc_in;
   logic signed [41:0] bs_ff, bs_in; // held old bin values for sweep
   logic [47:0] bq_ff, bq_in;
   logic [15:0] bc_ff, bc_in;
   logic        rsp_v_ff, rsp_v_in;
   logic        skip_ff, skip_in;
   // epoch working registers
   logic signed [41:0] ws_ff [3], ws_in [3];
   logic [25:0] wc_ff [3], wc_in [3];
   logic [57:0] wq_ff, wq_in;
   logic signed [42:0] mean_ff [3], mean_in [3];
   logic [63:0] qc_ff, qc_in, sig_ff, sig_in, root_ff, root_in;
   logic signed [43:0] depth_ff, depth_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] lo_ff, lo_in;

   // bin store ports
   logic        bin_we;
   logic [9:0]  bin_wa, bin_ra;
   logic [31:0] bs_rd;
   logic [47:0] bq_rd;
   logic [15:0] bc_rd;
   logic [31:0] bs_wd;
   logic [47:0] bq_wd;
   logic [15:0] bc_wd;
   // window store ports
   logic        win_we;
   logic [9:0]  win_wa, win_ra;
   logic [41:0] ws_rd;
   logic [57:0] wq_rd;
   logic [25:0] wc_rd;

   // divide / root unit
   logic        du_start, du_sqrt, du_done;
   logic [63:0] du_num, du_den, du_res;

   btps_ram #(.Width(32), .Depth(MaxBins)) u_bsum (.clock, .wr_en(bin_we),
      .wr_addr(bin_wa), .wr_data(bs_wd), .rd_addr(bin_ra), .rd_data(bs_rd));
   btps_ram #(.Width(48), .Depth(MaxBins)) u_bsq (.clock, .wr_en(bin_we),
      .wr_addr(bin_wa), .wr_data(bq_wd), .rd_addr(bin_ra), .rd_data(bq_rd));
   btps_ram #(.Width(16), .Depth(MaxBins)) u_bcnt (.clock, .wr_en(bin_we),
      .wr_addr(bin_wa), .wr_data(bc_wd), .rd_addr(bin_ra), .rd_data(bc_rd));
   btps_ram #(.Width(42), .Depth(MaxBins)) u_wsum (.clock, .wr_en(win_we),
      .wr_addr(win_wa), .wr_data(ts_ff), .rd_addr(win_ra), .rd_data(ws_rd));
   btps_ram #(.Width(58), .Depth(MaxBins)) u_wsq (.clock, .wr_en(win_we),
      .wr_addr(win_wa), .wr_data(tq_ff), .rd_addr(win_ra), .rd_data(wq_rd));
   btps_ram #(.Width(26), .Depth(MaxBins)) u_wcnt (.clock, .wr_en(win_we),
      .wr_addr(win_wa), .wr_data(tc_ff), .rd_addr(win_ra), .rd_data(wc_rd));

   btps_divsqrt u_du (.clock, .reset, .start(du_start), .is_sqrt(du_sqrt),
      .num(du_num), .den(du_den), .done(du_done), .result(du_res));

   // helpers
   logic [10:0] kb_w, ka_w, ksum;
   logic [10:0] pd;
   logic [11:0] jj;
   logic [63:0] amag;
   logic [63:0] mag;
   logic [63:0] prod;
   logic [63:0] hi_w;
   logic signed [43:0] half;
   logic signed [44:0] s_w;
   logic        neg;
   logic signed [32:0] s2n_w;

   always_comb begin
      pd   = p_ff - d_ff;
      ksum = {1'b0, k_ff} + pd;
      kb_w = (ksum >= p_ff) ? ksum - p_ff : ksum;
      ksum = {1'b0, k_ff} + d_ff;
      ka_w = (ksum >= p_ff) ? ksum - p_ff : ksum;
   end

   always_comb begin
      state_in = state_ff;
      p_in = p_ff; d_in = d_ff;
      best_in = best_ff; bidx_in = bidx_ff; bbin_in = bbin_ff; dcnt_in = dcnt_ff;
      i_in = i_ff; k_in = k_ff; sub_in = sub_ff;
      ts_in = ts_ff; tq_in = tq_ff; tc_in = tc_ff;
      bs_in = bs_ff; bq_in = bq_ff; bc_in = bc_ff;
      rsp_v_in = 1'b0; skip_in = skip_ff;
      for (int n = 0; n < 3; n++) begin
         ws_in[n] = ws_ff[n]; wc_in[n] = wc_ff[n]; mean_in[n] = mean_ff[n];
      end
      wq_in = wq_ff; qc_in = qc_ff; sig_in = sig_ff; root_in = root_ff;
      depth_in = depth_ff; sq_in = sq_ff; lo_in = lo_ff;
      bin_we = 1'b0; bin_wa = req_bin_index;
      bs_wd = req_bin_sum; bq_wd = req_bin_sqsum; bc_wd = req_bin_count;
      bin_ra = '0;
      win_we = 1'b0; win_wa = '0; win_ra = k_ff;
      du_start = 1'b0; du_sqrt = 1'b0; du_num = '0; du_den = 64'd1;
      jj = '0; amag = '0; mag = '0; prod = '0; hi_w = '0; half = '0; s_w = '0;
      neg = 1'b0; s2n_w = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == KindLoad) begin
                  bin_we = 1'b1;
               end else begin
                  p_in = (num_bins_ff == 11'd0) ? 11'd1 :
                         (num_bins_ff > 11'(MaxBins)) ? 11'(MaxBins) : num_bins_ff;
                  d_in = (req_duration == 11'd0) ? 11'd1 : req_duration;
                  if (d_in > p_in) d_in = p_in;
                  if (req_first_duration) begin
                     best_in = floor_ff; bidx_in = '0; bbin_in = '0; dcnt_in = '0;
                  end
                  ts_in = '0; tq_in = '0; tc_in = '0; i_in = '0;
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            // read bin i, add the one read last cycle
            bin_ra = i_ff[9:0];
            if (i_ff != 12'd0) begin
               ts_in = ts_ff + 42'(signed'(bs_rd));
               tq_in = tq_ff + 58'(bq_rd);
               tc_in = tc_ff + 26'(bc_rd);
            end
            i_in = i_ff + 12'd1;
            if (i_ff == {1'b0, d_ff}) begin
               i_in = '0; sub_in = '0; state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // step 0 write window i and read bin i, step 1 read bin j, step 2 update
            jj = i_ff + {1'b0, d_ff};
            if (jj >= {1'b0, p_ff}) jj = jj - {1'b0, p_ff};
            case (sub_ff)
               3'd0: begin
                  bin_ra = i_ff[9:0]; sub_in = 3'd1;
                  win_we = 1'b1; win_wa = i_ff[9:0];
               end
               3'd1: begin
                  bin_ra = jj[9:0];
                  bs_in = 42'(signed'(bs_rd)); bq_in = bq_rd; bc_in = bc_rd;
                  sub_in = 3'd2;
               end
               default: begin
                  ts_in = ts_ff - bs_ff + 42'(signed'(bs_rd));
                  tq_in = tq_ff - 58'(bq_ff) + 58'(bq_rd);
                  tc_in = tc_ff - 26'(bc_ff) + 26'(bc_rd);
                  sub_in = 3'd0;
                  i_in = i_ff + 12'd1;
                  if (i_ff + 12'd1 == {1'b0, p_ff}) begin
                     i_in = '0; k_in = '0; state_in = ST_EPOCH_RD;
                  end
               end
            endcase
         end
         ST_EPOCH_RD: begin
            // fetch during, before, after windows
            case (sub_ff)
               3'd0: begin win_ra = k_ff; sub_in = 3'd1; end
               3'd1: begin
                  win_ra = kb_w[9:0];
                  ws_in[0] = signed'(ws_rd); wc_in[0] = wc_rd; wq_in = wq_rd;
                  sub_in = 3'd2;
               end
               3'd2: begin
                  win_ra = ka_w[9:0];
                  ws_in[1] = signed'(ws_rd); wc_in[1] = wc_rd; sub_in = 3'd3;
               end
               default: begin
                  ws_in[2] = signed'(ws_rd); wc_in[2] = wc_rd;
                  sub_in = 3'd0; skip_in = 1'b0;
                  if (wc_ff[0] == 26'd0 || wc_ff[1] == 26'd0 || wc_rd == 26'd0) begin
                     state_in = ST_CMP; skip_in = 1'b1;
                  end else begin
                     state_in = ST_MEAN;
                  end
               end
            endcase
         end
         ST_MEAN: begin
            // sub 0..2: means of during, before, after; sub 3: sqsum / count
            if (sub_ff <= 3'd2) begin
               amag = ws_ff[sub_ff[1:0]][41] ? 64'(-ws_ff[sub_ff[1:0]])
                                            : 64'(ws_ff[sub_ff[1:0]]);
               du_num = amag;
               du_den = 64'(wc_ff[sub_ff[1:0]]);
            end else begin
               du_num = 64'(wq_ff);
               du_den = 64'(wc_ff[0]);
            end
            if (i_ff == 12'd0) begin
               du_start = 1'b1; i_in = 12'd1;
            end else if (du_done) begin
               i_in = '0;
               if (sub_ff <= 3'd2) begin
                  mean_in[sub_ff[1:0]] = ws_ff[sub_ff[1:0]][41] ?
                     -43'(du_res) : 43'(du_res);
                  sub_in = sub_ff + 3'd1;
               end else begin
                  qc_in = du_res; sub_in = '0;
                  amag = mean_ff[0][42] ? 64'(-mean_ff[0]) : 64'(mean_ff[0]);
                  sq_in = amag[31:0] * amag[31:0];
                  if (amag[63:32] != 32'd0) begin
                     skip_in = 1'b1; state_in = ST_CMP;
                  end else begin
                     state_in = ST_SQRT;
                  end
               end
            end
         end
         ST_SQRT: begin
            // sub 0: sigma = sqrt(qc - sq); sub 1: root = sqrt(count << 32)
            if (sub_ff == 3'd0 && i_ff == 12'd0 && qc_ff <= sq_ff) begin
               skip_in = 1'b1; state_in = ST_CMP;
            end else begin
               du_sqrt = 1'b1;
               du_num = (sub_ff == 3'd0) ? qc_ff - sq_ff : {6'd0, wc_ff[0], 32'd0};
               if (i_ff == 12'd0) begin
                  du_start = 1'b1; i_in = 12'd1;
               end else if (du_done) begin
                  i_in = '0;
                  if (sub_ff == 3'd0) begin
                     sig_in = du_res; sub_in = 3'd1;
                  end else begin
                     root_in = du_res; sub_in = '0;
                     s_w = 45'(mean_ff[1]) + 45'(mean_ff[2]);
                     half = 44'(s_w >>> 1);
                     depth_in = half - 44'(mean_ff[0]);
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            // q = |depth| * root / sigma, saturated; low product first, then high
            mag = depth_ff[43] ? 64'(-depth_ff) : 64'(depth_ff);
            hi_w = mag[63:32] * root_ff[31:0];
            prod = {hi_w[31:0], 32'd0} + lo_ff;
            if (sub_ff == 3'd0) begin
               lo_in = mag[31:0] * root_ff[31:0];
               sub_in = 3'd1;
            end else if (i_ff == 12'd0) begin
               if (hi_w[63:32] != 32'd0 || prod < lo_ff || prod >= (sig_ff << 31)) begin
                  sq_in = 64'h8000_0000; sub_in = '0; state_in = ST_CMP;
               end else begin
                  du_num = prod; du_den = sig_ff; du_start = 1'b1; i_in = 12'd1;
               end
            end else if (du_done) begin
               i_in = '0; sub_in = '0; sq_in = du_res; state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            neg = depth_ff[43];
            if (sq_ff[31]) begin
               s2n_w = neg ? -33'sh0_8000_0000 : 33'sh0_7FFF_FFFF;
            end else begin
               s2n_w = neg ? -33'(sq_ff[31:0]) : 33'(sq_ff[31:0]);
            end
            if (!skip_ff && s2n_w > 33'(best_ff)) begin
               best_in = s2n_w[31:0]; bidx_in = dcnt_ff; bbin_in = k_ff;
            end
            skip_in = 1'b0; sub_in = '0; i_in = '0;
            if ({1'b0, k_ff} + 11'd1 == p_ff) begin
               state_in = ST_DONE;
            end else begin
               k_in = k_ff + 10'd1; state_in = ST_EPOCH_RD;
            end
         end
         ST_DONE: begin
            dcnt_in = 8'(9'(dcnt_ff) + 9'd1 >= 9'(MaxDurations) ? 9'd0 :
                         9'(dcnt_ff) + 9'd1);
            rsp_v_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         num_bins_ff <= 11'd1024;
         floor_ff <= '0;
         best_ff <= '0; bidx_ff <= '0; bbin_ff <= '0; dcnt_ff <= '0;
         rsp_v_ff <= 1'b0; i_ff <= '0; sub_ff <= '0; skip_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en && csr_index == CsrNumBins) num_bins_ff <= csr_wr_data[10:0];
         if (csr_wr_en && csr_index == CsrS2nFloor) floor_ff <= csr_wr_data;
         best_ff <= best_in; bidx_ff <= bidx_in; bbin_ff <= bbin_in;
         dcnt_ff <= dcnt_in; rsp_v_ff <= rsp_v_in;
         i_ff <= i_in; sub_ff <= sub_in; skip_ff <= skip_in;
      end
      p_ff <= p_in; d_ff <= d_in; k_ff <= k_in;
      ts_ff <= ts_in; tq_ff <= tq_in; tc_ff <= tc_in;
      bs_ff <= bs_in; bq_ff <= bq_in; bc_ff <= bc_in;
      ws_ff <= ws_in; wc_ff <= wc_in; mean_ff <= mean_in; wq_ff <= wq_in;
      qc_ff <= qc_in; sig_ff <= sig_in; root_ff <= root_in;
      depth_ff <= depth_in; sq_ff <= sq_in; lo_ff <= lo_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_best_s2n = best_ff;
   assign rsp_best_duration_index = bidx_ff;
   assign rsp_best_epoch = bbin_ff;

`ifndef SYNTHESIS
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> $past(state_ff == ST_DONE)) else $error("stray result");
   a_no_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> !busy) else $error("result while busy");
   a_epoch_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> {1'b0, k_ff} < p_ff) else $error("epoch past P");
`endif
endmodule
